### rtl/fpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the fan pid controller
// widths, register indexes, command codes and controller gains
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int TEMP_W  = 8;
  localparam int LEVEL_W = 14;
  localparam int CMD_W   = 2;
  localparam int INTEG_W = 7;
  localparam int ERR_W   = 9;
  localparam int SUM_W   = 11;
  localparam int DRIVE_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_START_PWM = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_SPEED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP      = 2'd2;

  localparam logic [TEMP_W-1:0]  TARGET_RESET    = 8'd25;
  localparam logic [LEVEL_W-1:0] MIN_START_RESET = 14'd3000;
  localparam logic [LEVEL_W-1:0] PWM_FULL        = 14'd10000;
  localparam logic [INTEG_W-1:0] INT_LIMIT       = 7'd100;

  localparam logic signed [DRIVE_W-1:0] KP = 18'sd200;
  localparam logic signed [DRIVE_W-1:0] KI = 18'sd10;
  localparam logic signed [DRIVE_W-1:0] KD = 18'sd25;

  typedef logic [TEMP_W-1:0]  temp_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [CMD_W-1:0]   cmd_t;

endpackage

### rtl/fpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_in_if / fpd_out_if: sample and command channels
// valid/ready channels carrying the temperature sample and the pwm result
// ----------------------------------------------------------------------------
interface fpd_in_if;
  import fpd_pkg::*;
  logic  valid;
  logic  ready;
  temp_t temp_sample;
  modport source (output valid, output temp_sample, input ready);
  modport sink   (input valid, input temp_sample, output ready);
endinterface

interface fpd_out_if;
  import fpd_pkg::*;
  logic   valid;
  logic   ready;
  level_t drive_level;
  cmd_t   command;
  logic   fan_running;
  modport source (output valid, output drive_level, output command, output fan_running,
                  input ready);
  modport sink   (input valid, input drive_level, input command, input fan_running,
                  output ready);
endinterface

### rtl/fan_pid_with_deadband.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_pid_with_deadband: fan speed pid controller with deadband
// positional pid on whole-degree samples, integral clamp, pwm command result
// ----------------------------------------------------------------------------
// channel   | dir | payload
// ----------+-----+------------------------------------------------
// in_ch     | in  | temp_sample
// out_ch    | out | drive_level, command, fan_running
// cfg_*     | in  | write port: target_temp, manual_hold, auto_enable,
//           |     | min_start_pwm
//
// one transaction per cycle sustained while out_ch is ready; a sample passes
// the sample register, then the pid pass into the result register
// the sample register holds one transaction while the result is stalled
// rst sets the configuration registers to their defaults and clears the controller state
module fan_pid_with_deadband (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data,
  fpd_in_if.sink                         in_ch,
  fpd_out_if.source                      out_ch
);
  import fpd_pkg::*;

  temp_t  target_temp;
  logic   manual_hold;
  logic   auto_enable;
  level_t min_start_pwm;

  logic [INTEG_W-1:0]      integral_sum;
  logic signed [ERR_W-1:0] last_error;
  logic                    fan_on;

  logic  smp_vld;
  temp_t smp;

  logic   res_vld;
  level_t res_level;
  cmd_t   res_cmd;
  logic   res_fan;

  logic advance;

  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]   sum_raw;
  logic [INTEG_W-1:0]        integ_clamped;
  logic signed [DRIVE_W-1:0] drive;
  level_t                    drive_clamped;
  level_t                    start;

  logic [INTEG_W-1:0]      integral_sum_next;
  logic signed [ERR_W-1:0] last_error_next;
  logic                    fan_on_next;
  level_t                  level_next;
  cmd_t                    cmd_next;

  assign advance      = smp_vld && (!res_vld || out_ch.ready);
  assign in_ch.ready  = !smp_vld || advance;

  assign out_ch.valid       = res_vld;
  assign out_ch.drive_level = res_level;
  assign out_ch.command     = res_cmd;
  assign out_ch.fan_running = res_fan;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp   <= TARGET_RESET;
      manual_hold   <= 1'b0;
      auto_enable   <= 1'b1;
      min_start_pwm <= MIN_START_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_TEMP:   target_temp   <= cfg_data[TEMP_W-1:0];
        REG_MANUAL_HOLD:   manual_hold   <= cfg_data[0];
        REG_AUTO_ENABLE:   auto_enable   <= cfg_data[0];
        REG_MIN_START_PWM: min_start_pwm <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pid pass
  always_comb begin
    err     = $signed({1'b0, smp}) - $signed({1'b0, target_temp});
    sum_raw = $signed({{(SUM_W-INTEG_W){1'b0}}, integral_sum})
            + $signed({{(SUM_W-ERR_W-1){err[ERR_W-1]}}, err, 1'b0});
    if (sum_raw > $signed(SUM_W'(INT_LIMIT))) begin
      integ_clamped = INT_LIMIT;
    end else if (sum_raw < 0) begin
      integ_clamped = '0;
    end else begin
      integ_clamped = sum_raw[INTEG_W-1:0];
    end
    drive = DRIVE_W'(err) * KP
          + $signed({{(DRIVE_W-INTEG_W){1'b0}}, integ_clamped}) * KI
          + (DRIVE_W'(err) - DRIVE_W'(last_error)) * KD;
    if (drive < 0) begin
      drive_clamped = '0;
    end else if (drive > $signed(DRIVE_W'(PWM_FULL))) begin
      drive_clamped = PWM_FULL;
    end else begin
      drive_clamped = drive[LEVEL_W-1:0];
    end
    start = (min_start_pwm > PWM_FULL) ? PWM_FULL : min_start_pwm;
    if (drive_clamped != '0 && drive_clamped < start) begin
      drive_clamped = start;
    end

    integral_sum_next = integral_sum;
    last_error_next   = last_error;
    fan_on_next       = fan_on;
    level_next        = '0;
    cmd_next          = CMD_NONE;
    if (manual_hold || !auto_enable) begin
      cmd_next = CMD_NONE;
    end else if (err == 0) begin
      integral_sum_next = '0;
      if (fan_on) begin
        cmd_next    = CMD_STOP;
        fan_on_next = 1'b0;
      end
    end else begin
      integral_sum_next = integ_clamped;
      last_error_next   = err;
      if (drive_clamped != '0) begin
        level_next  = drive_clamped;
        cmd_next    = CMD_SET_SPEED;
        fan_on_next = 1'b1;
      end else if (fan_on) begin
        cmd_next    = CMD_STOP;
        fan_on_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_vld      <= 1'b0;
      res_vld      <= 1'b0;
      integral_sum <= '0;
      last_error   <= '0;
      fan_on       <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        smp_vld <= 1'b1;
      end else if (advance) begin
        smp_vld <= 1'b0;
      end
      if (advance) begin
        res_vld      <= 1'b1;
        integral_sum <= integral_sum_next;
        last_error   <= last_error_next;
        fan_on       <= fan_on_next;
      end else if (out_ch.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      smp <= in_ch.temp_sample;
    end
    if (advance) begin
      res_level <= level_next;
      res_cmd   <= cmd_next;
      res_fan   <= fan_on_next;
    end
  end

  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    integral_sum <= INT_LIMIT)
    else $error("integral outside clamp range");

  a_level_cmd: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> ((res_level != '0) == (res_cmd == CMD_SET_SPEED)))
    else $error("drive level disagrees with command");

  a_fan_flag: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> (res_fan == fan_on))
    else $error("fan flag differs from controller state");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_vld && !out_ch.ready && smp_vld) |-> !in_ch.ready)
    else $error("sample accepted while both stages full");

endmodule
